/* rtl/ssid_ip_field_extractor_assert.svh */
// Assertion macros shared by the extractor modules.
`ifndef SSID_IP_FIELD_EXTRACTOR_ASSERT_SVH
`define SSID_IP_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SIFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sife_pkg.sv */
// Types and constants for the name and address field extractor.
`default_nettype none

package sife_pkg;

    localparam logic [7:0] CH_NULL   = 8'h00;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;

    localparam logic [1:0] PERIOD_MAX   = 2'd3;
    localparam logic [1:0] PERIOD_SPLIT = 2'd2;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int OUT_W    = 24;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    typedef struct packed {
        logic [POS_W-1:0]  ip_pos;
        logic              ip_part;
        logic              ip_write;
        logic [POS_W-1:0]  ssid_pos;
        logic              ssid_write;
        logic [BYTE_W-1:0] forward_byte;
        logic              forward_valid;
    } result_t;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic    valid;
        result_t item;
    } q_head_t;

endpackage

`default_nettype wire

/* rtl/ssid_ip_field_extractor.sv */
// Top level of the name and address field extractor.
//
//  channel  | dir | tdata fields (lowest bit first)
//  ---------+-----+----------------------------------------------------------------
//  s_axis   | in  | rx_byte[7:0]
//  m_axis   | out | forward_valid, forward_byte[7:0], ssid_write, ssid_pos[3:0],
//           |     | ip_write, ip_part, ip_pos[3:0], 4 zero bits
//
//  One result beat per accepted byte, null bytes included; one byte per cycle sustained
//  while m_axis_tready is high. The front end settles its fields in the accepting cycle,
//  the queue stores them, and the output register loads them from the queue head.
//  Reset clears all field state and empties the two-entry queue and output register.
//  A stalled output fills the queue; s_axis_tready drops only while the queue is full.
`default_nettype none

module ssid_ip_field_extractor
    import sife_pkg::*;
#(
    parameter int PART_CAPACITY = 16,
    parameter int NAME_LIMIT    = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // rx_byte
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata    // forward_valid, forward_byte, ssid_write,
                                                  // ssid_pos, ip_write, ip_part, ip_pos
);

    logic    accept;
    logic    q_full;
    logic    q_pop;
    result_t front_result;
    q_head_t q_head;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sife_front #(
        .PART_CAPACITY (PART_CAPACITY),
        .NAME_LIMIT    (NAME_LIMIT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_axis_tdata),
        .result  (front_result)
    );

    sife_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_result),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    sife_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* rtl/sife_front.sv */
// Front end: takes each received byte, tracks the field state and builds its result.
`default_nettype none
`include "ssid_ip_field_extractor_assert.svh"

module sife_front
    import sife_pkg::*;
#(
    parameter int PART_CAPACITY = 16,
    parameter int NAME_LIMIT    = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output result_t                result
);

    localparam int SC_RAW = $clog2(NAME_LIMIT + 1);
    localparam int SC_W   = (SC_RAW > POS_W) ? SC_RAW : POS_W;
    localparam int PC_RAW = $clog2(PART_CAPACITY + 1);
    localparam int PC_W   = (PC_RAW > POS_W) ? PC_RAW : POS_W;
    localparam logic [SC_W-1:0] NAME_MAX = SC_W'(NAME_LIMIT);
    localparam logic [PC_W-1:0] PART_MAX = PC_W'(PART_CAPACITY);

    logic [BYTE_W-1:0] prev_reg,         prev_next;
    logic [BYTE_W-1:0] prev_prev_reg,    prev_prev_next;
    logic              ssid_active_reg,  ssid_active_next;
    logic [SC_W-1:0]   ssid_count_reg,   ssid_count_next;
    logic              ip_active_reg,    ip_active_next;
    logic              in_first_reg,     in_first_next;
    logic              in_second_reg,    in_second_next;
    logic [1:0]        period_count_reg, period_count_next;
    logic [PC_W-1:0]   first_count_reg,  first_count_next;
    logic [PC_W-1:0]   second_count_reg, second_count_next;

    always_comb
    begin
        prev_next         = prev_reg;
        prev_prev_next    = prev_prev_reg;
        ssid_active_next  = ssid_active_reg;
        ssid_count_next   = ssid_count_reg;
        ip_active_next    = ip_active_reg;
        in_first_next     = in_first_reg;
        in_second_next    = in_second_reg;
        period_count_next = period_count_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        result            = '0;

        if (rx_byte != CH_NULL)
        begin
            result.forward_valid = 1'b1;
            result.forward_byte  = rx_byte;

            if (ssid_active_reg)
            begin
                result.ssid_write = 1'b1;
                result.ssid_pos   = ssid_count_reg[POS_W-1:0];
                ssid_count_next   = ssid_count_reg + 1'b1;
                if (rx_byte == CH_QUOTE || ssid_count_next >= NAME_MAX)
                begin
                    ssid_active_next = 1'b0;
                end
            end
            // Start check uses the updated count, so a closing quote after a colon restarts.
            if (ssid_count_next < NAME_MAX && prev_reg == CH_COLON && rx_byte == CH_QUOTE)
            begin
                ssid_active_next = 1'b1;
            end

            if (ip_active_reg)
            begin
                if (period_count_reg < PERIOD_MAX && rx_byte == CH_PERIOD)
                begin
                    period_count_next = period_count_reg + 1'b1;
                end
                if (in_first_reg)
                begin
                    if (first_count_reg < PART_MAX)
                    begin
                        result.ip_write  = 1'b1;
                        result.ip_part   = 1'b0;
                        result.ip_pos    = first_count_reg[POS_W-1:0];
                        first_count_next = first_count_reg + 1'b1;
                    end
                end
                else if (in_second_reg)
                begin
                    if (second_count_reg < PART_MAX)
                    begin
                        result.ip_write   = 1'b1;
                        result.ip_part    = 1'b1;
                        result.ip_pos     = second_count_reg[POS_W-1:0];
                        second_count_next = second_count_reg + 1'b1;
                    end
                end
                if (period_count_next == PERIOD_SPLIT)
                begin
                    in_first_next  = 1'b0;
                    in_second_next = 1'b1;
                end
                if (rx_byte == CH_QUOTE)
                begin
                    ip_active_next = 1'b0;
                end
            end
            if (first_count_next == '0 && prev_prev_reg == CH_P && prev_reg == CH_COMMA
                && rx_byte == CH_QUOTE)
            begin
                in_first_next  = 1'b1;
                ip_active_next = 1'b1;
            end

            prev_prev_next = prev_reg;
            prev_next      = rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg         <= '0;
            prev_prev_reg    <= '0;
            ssid_active_reg  <= 1'b0;
            ssid_count_reg   <= '0;
            ip_active_reg    <= 1'b0;
            in_first_reg     <= 1'b0;
            in_second_reg    <= 1'b0;
            period_count_reg <= '0;
            first_count_reg  <= '0;
            second_count_reg <= '0;
        end
        else if (accept)
        begin
            prev_reg         <= prev_next;
            prev_prev_reg    <= prev_prev_next;
            ssid_active_reg  <= ssid_active_next;
            ssid_count_reg   <= ssid_count_next;
            ip_active_reg    <= ip_active_next;
            in_first_reg     <= in_first_next;
            in_second_reg    <= in_second_next;
            period_count_reg <= period_count_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
        end
    end

    `SIFE_ASSERT_NOW(a_name_count_bound, 1'b1, ssid_count_reg <= NAME_MAX,
        "name count beyond limit")
    `SIFE_ASSERT_NOW(a_part_count_bound, 1'b1,
        first_count_reg <= PART_MAX && second_count_reg <= PART_MAX,
        "address part count beyond capacity")
    `SIFE_ASSERT_NOW(a_name_needs_room, accept && result.ssid_write,
        ssid_count_reg < NAME_MAX, "name character written with no room left")

endmodule

`default_nettype wire

/* rtl/sife_queue.sv */
// Short result queue between the front and back ends.
`default_nettype none
`include "ssid_ip_field_extractor_assert.svh"

module sife_queue
    import sife_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_item,
    output logic         full,
    input  wire logic    pop,
    output q_head_t      head
);

    result_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg,  count_next;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SIFE_ASSERT_NOW(a_no_overflow, push, !full, "push into a full queue")
    `SIFE_ASSERT_NOW(a_no_underflow, pop, head.valid, "pop from an empty queue")
    `SIFE_ASSERT_NEXT(a_push_lands, push && !pop, count_reg != '0,
        "queue empty right after a push")

endmodule

`default_nettype wire

/* rtl/sife_back.sv */
// Back end: output register that drives the result stream.
`default_nettype none

module sife_back
    import sife_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire q_head_t     head,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg;

    // Load from a valid queue head whenever the register is empty or its beat leaves this cycle.
    assign pop = head.valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= OUT_W'(head.item);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the name and address field extractor.
`timescale 1ns / 100ps

module tb_top;
    import sife_pkg::*;

    localparam int PART_CAPACITY = 16;
    localparam int NAME_LIMIT    = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int TRAFFIC_ITEMS = 275;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = 8'h00;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    // predictor state
    logic [7:0] last_byte;
    logic [7:0] older_byte;
    logic       name_on;
    logic [3:0] name_cnt;
    logic       addr_on;
    logic       in_part0;
    logic       in_part1;
    logic [1:0] dot_cnt;
    logic [4:0] part0_cnt;
    logic [4:0] part1_cnt;

    result_t expected_beats[$];

    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    int null_count;
    int name_chars;
    int addr_chars;
    int addr_drops;
    int error_count;
    int quiet_cycles;

    ssid_ip_field_extractor #(
        .PART_CAPACITY (PART_CAPACITY),
        .NAME_LIMIT    (NAME_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Works out the result beat for one received byte and advances the field state.
    function automatic result_t extract_fields(input logic [7:0] b);
        result_t r;
        r = '0;
        if (b != CH_NULL)
        begin
            r.forward_valid = 1'b1;
            r.forward_byte  = b;

            if (name_on)
            begin
                r.ssid_write = 1'b1;
                r.ssid_pos   = name_cnt;
                name_cnt     = name_cnt + 4'd1;
                if (b == CH_QUOTE || name_cnt >= NAME_LIMIT)
                    name_on = 1'b0;
            end
            // check for a new name only after the current byte has been taken
            if (name_cnt < NAME_LIMIT && last_byte == CH_COLON && b == CH_QUOTE)
                name_on = 1'b1;

            if (addr_on)
            begin
                if (dot_cnt < PERIOD_MAX && b == CH_PERIOD)
                    dot_cnt = dot_cnt + 2'd1;
                if (in_part0)
                begin
                    if (part0_cnt < PART_CAPACITY)
                    begin
                        r.ip_write = 1'b1;
                        r.ip_part  = 1'b0;
                        r.ip_pos   = part0_cnt[3:0];
                        part0_cnt  = part0_cnt + 5'd1;
                    end
                    else
                        addr_drops++;
                end
                else if (in_part1)
                begin
                    if (part1_cnt < PART_CAPACITY)
                    begin
                        r.ip_write = 1'b1;
                        r.ip_part  = 1'b1;
                        r.ip_pos   = part1_cnt[3:0];
                        part1_cnt  = part1_cnt + 5'd1;
                    end
                    else
                        addr_drops++;
                end
                if (dot_cnt == PERIOD_SPLIT)
                begin
                    in_part0 = 1'b0;
                    in_part1 = 1'b1;
                end
                if (b == CH_QUOTE)
                    addr_on = 1'b0;
            end
            if (part0_cnt == 0 && older_byte == CH_P && last_byte == CH_COMMA &&
                b == CH_QUOTE)
            begin
                in_part0 = 1'b1;
                addr_on  = 1'b1;
            end

            older_byte = last_byte;
            last_byte  = b;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Predict on each input beat; compare each output beat with the oldest prediction.
    always @(posedge clk)
    begin : scoreboard
        result_t exp_beat;
        result_t got_beat;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_beat = extract_fields(s_axis_tdata);
                expected_beats.push_back(exp_beat);
                if (!exp_beat.forward_valid)
                    null_count++;
                if (exp_beat.ssid_write)
                    name_chars++;
                if (exp_beat.ip_write)
                    addr_chars++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_beat = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected output beat 0x%0h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    exp_beat = expected_beats.pop_front();
                    check_field("forward_valid", exp_beat.forward_valid,
                                got_beat.forward_valid);
                    check_field("forward_byte", exp_beat.forward_byte,
                                got_beat.forward_byte);
                    check_field("ssid_write", exp_beat.ssid_write, got_beat.ssid_write);
                    check_field("ssid_pos", exp_beat.ssid_pos, got_beat.ssid_pos);
                    check_field("ip_write", exp_beat.ip_write, got_beat.ip_write);
                    check_field("ip_part", exp_beat.ip_part, got_beat.ip_part);
                    check_field("ip_pos", exp_beat.ip_pos, got_beat.ip_pos);
                    check_field("pad", 0, m_axis_tdata[OUT_W-1:$bits(result_t)]);
                end
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // End the run when neither side has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: timeout after %0d idle cycles", quiet_cycles);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
    endtask

    // Hold the sender until every predicted beat has come out.
    task automatic drain_results();
        idle_input();
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_PERIOD);
        return b;
    endfunction

    task automatic test_byte_extremes();
        send_byte(CH_NULL);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(CH_NULL);
        send_byte(8'h7F);
        drain_results();
    endtask

    task automatic test_name_capture();
        // a null between colon and quote leaves the history alone
        send_byte(CH_COLON);
        send_byte(CH_NULL);
        send_byte(CH_QUOTE);
        // the closing quote follows a colon, so recording starts again at once
        send_byte(CH_COLON);
        send_byte(CH_QUOTE);
        for (int i = 0; i < 8; i++)
            send_byte(8'h41 + 8'(i));
        // name limit reached: no further start
        send_byte(CH_COLON);
        send_byte(CH_QUOTE);
        send_byte(8'h5A);
        drain_results();
    endtask

    task automatic addr_frame();
        int n0;
        int n1;
        int n2;
        n0 = $urandom_range(0, 18);
        n1 = $urandom_range(0, 18);
        n2 = $urandom_range(0, 20);
        send_byte(CH_P);
        if ($urandom_range(9) == 0)
            send_byte(CH_NULL);
        send_byte(CH_COMMA);
        send_byte(CH_QUOTE);
        repeat (n0)
            send_byte(($urandom_range(19) == 0) ? CH_NULL : plain_char());
        send_byte(CH_PERIOD);
        repeat (n1)
            send_byte(($urandom_range(19) == 0) ? CH_NULL : plain_char());
        send_byte(CH_PERIOD);
        repeat (n2)
            send_byte(($urandom_range(4) == 0) ? CH_PERIOD : plain_char());
        if ($urandom_range(9) < 8)
            send_byte(CH_QUOTE);
    endtask

    task automatic name_frame();
        send_byte(CH_COLON);
        send_byte(CH_QUOTE);
        repeat ($urandom_range(0, 12))
            send_byte(plain_char());
        if ($urandom_range(9) < 7)
            send_byte(CH_QUOTE);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_byte(($urandom_range(3) == 0) ? CH_NULL : 8'($urandom_range(0, 255)));
    endtask

    task automatic run_traffic(input int idle_pct, input int stall_pct, input int items);
        int start_count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = bytes_sent;
        while (bytes_sent - start_count < items)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: addr_frame();
                5, 6:          name_frame();
                default:       noise_burst();
            endcase
            if ($urandom_range(29) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        last_byte      = '0;
        older_byte     = '0;
        name_on        = 1'b0;
        name_cnt       = '0;
        addr_on        = 1'b0;
        in_part0       = 1'b0;
        in_part1       = 1'b0;
        dot_cnt        = '0;
        part0_cnt      = '0;
        part1_cnt      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        null_count     = 0;
        name_chars     = 0;
        addr_chars     = 0;
        addr_drops     = 0;
        error_count    = 0;
        quiet_cycles   = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_extremes();
        test_name_capture();
        run_traffic(0, 0, TRAFFIC_ITEMS);
        run_traffic(83, 0, TRAFFIC_ITEMS);
        run_traffic(0, 83, TRAFFIC_ITEMS);
        run_traffic(9, 9, TRAFFIC_ITEMS);

        repeat (8) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $error("%0d output beats never arrived", expected_beats.size());
            error_count++;
        end

        $display("tb_top: %0d bytes in (%0d nulls) across four back-pressure mixes",
                 bytes_sent, null_count);
        $display("tb_top: %0d name and %0d address characters stored, %0d dropped at full",
                 name_chars, addr_chars, addr_drops);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
